/* src/sha_pkg.sv */
package sha_pkg;

	localparam logic [31:0] H_INIT [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [31:0] ROUND_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	localparam logic [7:0] PAD_BYTE = 8'h80;
	localparam int         LEN_POS  = 56;

	// word passed from front to back
	typedef struct packed {
		logic [7:0] data_byte;
		logic       has_data;
		logic       end_of_message;
	} sha_item_t;

	function automatic logic [31:0] ror(input logic [31:0] x, input int n);
		ror = (x >> n) | (x << (32 - n));
	endfunction

endpackage

/* src/sha_front.sv */
module sha_front
	import sha_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      valid,
	output logic      stall,
	input  logic [7:0] data_byte,
	input  logic      has_data,
	input  logic      end_of_message,
	output logic      q_valid,
	input  logic      q_pop,
	output sha_item_t q_item
);

	// two-entry queue; idle items are dropped here
	sha_item_t mem_q [2];
	logic      wr_q, rd_q;
	logic [1:0] cnt_q;
	logic      push;

	assign stall   = (cnt_q == 2'd2);
	assign push    = valid && !stall && (has_data || end_of_message);
	assign q_valid = (cnt_q != 2'd0);
	assign q_item  = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push)
				wr_q <= !wr_q;
			if (q_pop && q_valid)
				rd_q <= !rd_q;
			cnt_q <= cnt_q + 2'(push) - 2'(q_pop && q_valid);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= '{data_byte, has_data, end_of_message};
	end

endmodule

/* src/sha_back.sv */
module sha_back
	import sha_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_valid,
	output logic        q_pop,
	input  sha_item_t   q_item,
	output logic        valid,
	input  logic        stall,
	output logic [31:0] digest_word,
	output logic [2:0]  word_index,
	output logic        last_word
);

	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_PAD  = 7'b0000010,
		ST_LOAD = 7'b0000100,
		ST_RND  = 7'b0001000,
		ST_ADD  = 7'b0010000,
		ST_OUT  = 7'b0100000,
		ST_INIT = 7'b1000000
	} st_t;

	st_t         st_q;
	logic [31:0] h_q [8];
	logic [31:0] v_q [8];
	logic [31:0] w_q [16];
	logic [31:0] blk_q [16];
	logic [60:0] cnt_q;
	logic [5:0]  pos_q;
	logic [5:0]  rnd_q;
	logic        fin_q;
	logic        last_blk_q;
	logic        extra_q;
	logic [2:0]  oidx_q;
	logic        ovalid_q;
	logic [31:0] oword_q;

	logic [31:0] big0, big1, ch, maj, t1, t2, s0, s1, wnext;
	logic [63:0] bits;
	logic [7:0]  pad_byte;
	logic        take;

	assign bits  = {cnt_q, 3'b000};
	assign take  = (st_q == ST_IDLE) && q_valid;
	assign q_pop = take;

	always_comb begin
		big1 = ror(v_q[4], 6) ^ ror(v_q[4], 11) ^ ror(v_q[4], 25);
		ch   = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
		t1   = v_q[7] + big1 + ch + ROUND_K[rnd_q] + w_q[0];
		big0 = ror(v_q[0], 2) ^ ror(v_q[0], 13) ^ ror(v_q[0], 22);
		maj  = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
		t2   = big0 + maj;
		s0   = ror(w_q[1], 7) ^ ror(w_q[1], 18) ^ (w_q[1] >> 3);
		s1   = ror(w_q[14], 17) ^ ror(w_q[14], 19) ^ (w_q[14] >> 10);
		wnext = w_q[0] + s0 + w_q[9] + s1;
	end

	// padding byte for position pos_q after the 0x80 marker
	always_comb begin
		pad_byte = 8'h00;
		if (last_blk_q && pos_q >= 6'(LEN_POS))
			pad_byte = bits[{~pos_q[2:0], 3'b000} +: 8];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= ST_IDLE;
			cnt_q    <= '0;
			pos_q    <= '0;
			rnd_q    <= '0;
			fin_q    <= 1'b0;
			last_blk_q <= 1'b0;
			extra_q  <= 1'b0;
			oidx_q   <= '0;
			ovalid_q <= 1'b0;
			for (int i = 0; i < 8; i++)
				h_q[i] <= H_INIT[i];
		end else begin
			if (ovalid_q && !stall && st_q != ST_OUT)
				ovalid_q <= 1'b0;
			case (st_q)
				ST_IDLE: begin
					if (take) begin
						fin_q <= q_item.end_of_message;
						if (q_item.has_data) begin
							pos_q <= pos_q + 6'd1;
							cnt_q <= cnt_q + 61'd1;
							last_blk_q <= 1'b0;
							if (pos_q == 6'd63)
								st_q <= ST_LOAD;
							else if (q_item.end_of_message)
								st_q <= ST_PAD;
						end else begin
							st_q <= ST_PAD;
						end
					end
				end
				ST_PAD: begin
					// first entry writes marker; fin_q cleared marks marker done
					if (fin_q) begin
						fin_q      <= 1'b0;
						last_blk_q <= (pos_q < 6'(LEN_POS));
						extra_q    <= (pos_q >= 6'(LEN_POS));
						pos_q      <= pos_q + 6'd1;
						if (pos_q == 6'd63)
							st_q <= ST_LOAD;
					end else begin
						pos_q <= pos_q + 6'd1;
						if (pos_q == 6'd63)
							st_q <= ST_LOAD;
					end
				end
				ST_LOAD: begin
					for (int i = 0; i < 8; i++)
						v_q[i] <= h_q[i];
					for (int i = 0; i < 16; i++)
						w_q[i] <= blk_q[i];
					rnd_q <= '0;
					st_q  <= ST_RND;
				end
				ST_RND: begin
					v_q[7] <= v_q[6];
					v_q[6] <= v_q[5];
					v_q[5] <= v_q[4];
					v_q[4] <= v_q[3] + t1;
					v_q[3] <= v_q[2];
					v_q[2] <= v_q[1];
					v_q[1] <= v_q[0];
					v_q[0] <= t1 + t2;
					for (int i = 0; i < 15; i++)
						w_q[i] <= w_q[i+1];
					w_q[15] <= wnext;
					rnd_q <= rnd_q + 6'd1;
					if (rnd_q == 6'd63)
						st_q <= ST_ADD;
				end
				ST_ADD: begin
					for (int i = 0; i < 8; i++)
						h_q[i] <= h_q[i] + v_q[i];
					oidx_q <= '0;
					if (last_blk_q) begin
						st_q <= ST_OUT;
					end else if (fin_q) begin
						st_q <= ST_PAD;
					end else if (extra_q) begin
						// marker left no room for the length: one more block
						extra_q    <= 1'b0;
						last_blk_q <= 1'b1;
						st_q       <= ST_PAD;
					end else begin
						st_q <= ST_IDLE;
					end
				end
				ST_OUT: begin
					if (!ovalid_q || !stall) begin
						ovalid_q <= 1'b1;
						oword_q  <= h_q[oidx_q];
						oidx_q   <= oidx_q + 3'd1;
						if (oidx_q == 3'd7)
							st_q <= ST_INIT;
					end
				end
				ST_INIT: begin
					for (int i = 0; i < 8; i++)
						h_q[i] <= H_INIT[i];
					cnt_q      <= '0;
					pos_q      <= '0;
					last_blk_q <= 1'b0;
					st_q       <= ST_IDLE;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (take && q_item.has_data)
			blk_q[pos_q[5:2]][{~pos_q[1:0], 3'b000} +: 8] <= q_item.data_byte;
		else if (st_q == ST_PAD)
			blk_q[pos_q[5:2]][{~pos_q[1:0], 3'b000} +: 8] <= fin_q ? PAD_BYTE : pad_byte;
	end

	assign valid       = ovalid_q;
	assign digest_word = oword_q;
	assign word_index  = oidx_q - 3'd1;
	assign last_word   = (word_index == 3'd7);

endmodule

/* src/sha256_message_hasher.sv */
// Hash update after a block's 64th byte reaches the back: load, 64 rounds,
// add. Front queue registers bytes; the back takes none while it hashes.
// Message end: padding byte by byte to block end, then the hash update; a
// second padded block when the marker lands at byte 56 or later; then eight
// digest words, one per cycle when not stalled. Reset (arst_n low, async)
// loads H0..H7.
module sha256_message_hasher
	import sha_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        has_data,
	input  logic        end_of_message,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] digest_word,
	output logic [2:0]  word_index,
	output logic        last_word
);

	logic      q_valid, q_pop;
	sha_item_t q_item;

	sha_front u_front (
		.clk, .arst_n, .valid(in_valid), .stall(in_stall),
		.data_byte, .has_data, .end_of_message,
		.q_valid, .q_pop, .q_item
	);

	sha_back u_back (
		.clk, .arst_n, .q_valid, .q_pop, .q_item,
		.valid(out_valid), .stall(out_stall),
		.digest_word, .word_index, .last_word
	);

`ifndef SYNTHESIS
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(digest_word))
		else $error("digest word dropped under stall");
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last_word |-> word_index == 3'd7)
		else $error("last flag misplaced");
`endif

endmodule
